FILE: src/tgmc_pkg.sv
`default_nettype none
package tgmc_pkg;

	// Quotient bits produced by the divider (enough to cover 2^48 plus the sign case)
	localparam int DIV_BITS = 49;
	// Metric determinant width, unsigned
	localparam int DEN_W = 128;
	// Dividend width after scaling and the rounding offset
	localparam int NUM_W = 141;
	// Remainder width: doubled denominator shifted by the top quotient bit
	localparam int REM_W = DEN_W + 1 + DIV_BITS;
	// Result width
	localparam int OUT_W = 48;
	// Fraction alignment shifts (doubled for round-half-away)
	localparam int GAUSS_SHL = 57;
	localparam int MEAN_SHL = 40;

	localparam logic [OUT_W-1:0] SAT_POS = 48'h7FFF_FFFF_FFFF;
	localparam logic [OUT_W-1:0] SAT_NEG = 48'h8000_0000_0000;

	// One triangle as it arrives
	typedef struct packed {
		logic signed [31:0] s_11;
		logic signed [31:0] s_10;
		logic signed [31:0] s_01;
		logic signed [31:0] s_00;
		logic signed [31:0] f_21;
		logic signed [31:0] f_11;
		logic signed [31:0] f_01;
		logic signed [31:0] f_20;
		logic signed [31:0] f_10;
		logic signed [31:0] f_00;
	} tgmc_in_t;

	// Dividends, doubled divisor and sign/flag bits handed to the divider
	typedef struct packed {
		logic [NUM_W-1:0] num_g;
		logic [NUM_W-1:0] num_m;
		logic [DEN_W:0]   den2;
		logic             neg_g;
		logic             neg_m;
		logic             singular;
	} tgmc_div_in_t;

	// One result
	typedef struct packed {
		logic             singular;
		logic [OUT_W-1:0] mean_curvature;
		logic [OUT_W-1:0] gauss_curvature;
	} tgmc_out_t;

endpackage
`default_nettype wire

FILE: src/tgmc_front.sv
`default_nettype none
module tgmc_front
	import tgmc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire tgmc_in_t     in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output tgmc_div_in_t      out_data
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

	// A stage loads when empty or when the next one moves
	assign en_s7 = !v_s7 || out_ready;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign out_valid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	// Stage 1: element products of F and S
	logic signed [63:0] paa0_s1, paa1_s1, paa2_s1;
	logic signed [63:0] pab0_s1, pab1_s1, pab2_s1;
	logic signed [63:0] pbb0_s1, pbb1_s1, pbb2_s1;
	logic signed [63:0] pss_s1, pst_s1;
	logic signed [32:0] ssum_s1;
	logic signed [31:0] s00_s1, s11_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			paa0_s1 <= 64'(in_data.f_00) * 64'(in_data.f_00);
			paa1_s1 <= 64'(in_data.f_10) * 64'(in_data.f_10);
			paa2_s1 <= 64'(in_data.f_20) * 64'(in_data.f_20);
			pab0_s1 <= 64'(in_data.f_00) * 64'(in_data.f_01);
			pab1_s1 <= 64'(in_data.f_10) * 64'(in_data.f_11);
			pab2_s1 <= 64'(in_data.f_20) * 64'(in_data.f_21);
			pbb0_s1 <= 64'(in_data.f_01) * 64'(in_data.f_01);
			pbb1_s1 <= 64'(in_data.f_11) * 64'(in_data.f_11);
			pbb2_s1 <= 64'(in_data.f_21) * 64'(in_data.f_21);
			pss_s1  <= 64'(in_data.s_00) * 64'(in_data.s_11);
			pst_s1  <= 64'(in_data.s_01) * 64'(in_data.s_10);
			ssum_s1 <= 33'(in_data.s_01) + 33'(in_data.s_10);
			s00_s1  <= in_data.s_00;
			s11_s1  <= in_data.s_11;
		end
	end

	// Stage 2: metric entries and det(S)
	logic [63:0]        g00_s2, g11_s2;
	logic signed [65:0] g01_s2;
	logic signed [64:0] dets_s2;
	logic signed [32:0] ssum_s2;
	logic signed [31:0] s00_s2, s11_s2;
	logic signed [65:0] g00_w, g11_w;

	always_comb begin
		g00_w = 66'(paa0_s1) + 66'(paa1_s1) + 66'(paa2_s1);
		g11_w = 66'(pbb0_s1) + 66'(pbb1_s1) + 66'(pbb2_s1);
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			g00_s2  <= g00_w[63:0];
			g11_s2  <= g11_w[63:0];
			g01_s2  <= 66'(pab0_s1) + 66'(pab1_s1) + 66'(pab2_s1);
			dets_s2 <= 65'(pss_s1) - 65'(pst_s1);
			ssum_s2 <= ssum_s1;
			s00_s2  <= s00_s1;
			s11_s2  <= s11_s1;
		end
	end

	// Stage 3: 32-bit partial products of the wide terms
	logic [31:0]        g01_lo;
	logic signed [33:0] g01_hi;
	assign g01_lo = g01_s2[31:0];
	assign g01_hi = $signed(g01_s2[65:32]);

	logic [63:0]        pgg_ll_s3, pgg_lh_s3, pgg_hl_s3, pgg_hh_s3;
	logic [63:0]        pq_ll_s3;
	logic signed [66:0] pq_lh_s3;
	logic signed [67:0] pq_hh_s3;
	logic signed [64:0] pt1l_s3, pt1h_s3, pt2l_s3, pt2h_s3;
	logic signed [65:0] pt3l_s3;
	logic signed [66:0] pt3h_s3;
	logic signed [64:0] dets_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			pgg_ll_s3 <= 64'(g00_s2[31:0]) * 64'(g11_s2[31:0]);
			pgg_lh_s3 <= 64'(g00_s2[31:0]) * 64'(g11_s2[63:32]);
			pgg_hl_s3 <= 64'(g00_s2[63:32]) * 64'(g11_s2[31:0]);
			pgg_hh_s3 <= 64'(g00_s2[63:32]) * 64'(g11_s2[63:32]);
			pq_ll_s3  <= 64'(g01_lo) * 64'(g01_lo);
			pq_lh_s3  <= 67'($signed({1'b0, g01_lo})) * 67'(g01_hi);
			pq_hh_s3  <= 68'(g01_hi) * 68'(g01_hi);
			pt1l_s3   <= 65'($signed({1'b0, g11_s2[31:0]})) * 65'(s00_s2);
			pt1h_s3   <= 65'($signed({1'b0, g11_s2[63:32]})) * 65'(s00_s2);
			pt2l_s3   <= 65'($signed({1'b0, g00_s2[31:0]})) * 65'(s11_s2);
			pt2h_s3   <= 65'($signed({1'b0, g00_s2[63:32]})) * 65'(s11_s2);
			pt3l_s3   <= 66'($signed({1'b0, g01_lo})) * 66'(ssum_s2);
			pt3h_s3   <= 67'(g01_hi) * 67'(ssum_s2);
			dets_s3   <= dets_s2;
		end
	end

	// Stage 4: recombine partials into g00*g11, g01^2 and the trace terms
	logic [127:0]        gg_w;
	logic signed [129:0] qhh_x, qlh_x, qll_x, q2_w;
	logic signed [97:0]  t1h_x, t1l_x, t2h_x, t2l_x;
	logic signed [99:0]  t3h_x, t3l_x;

	always_comb begin
		gg_w  = ({64'd0, pgg_hh_s3} << 64) + ({64'd0, pgg_lh_s3} << 32)
			+ ({64'd0, pgg_hl_s3} << 32) + {64'd0, pgg_ll_s3};
		qhh_x = 130'(pq_hh_s3);
		qlh_x = 130'(pq_lh_s3);
		qll_x = $signed({66'd0, pq_ll_s3});
		q2_w  = (qhh_x <<< 64) + (qlh_x <<< 33) + qll_x;
		t1h_x = 98'(pt1h_s3);
		t1l_x = 98'(pt1l_s3);
		t2h_x = 98'(pt2h_s3);
		t2l_x = 98'(pt2l_s3);
		t3h_x = 100'(pt3h_s3);
		t3l_x = 100'(pt3l_s3);
	end

	logic [127:0]       gg_s4, q2_s4;
	logic signed [97:0] t1_s4, t2_s4;
	logic signed [99:0] t3_s4;
	logic signed [64:0] dets_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			gg_s4   <= gg_w;
			q2_s4   <= q2_w[127:0];
			t1_s4   <= (t1h_x <<< 32) + t1l_x;
			t2_s4   <= (t2h_x <<< 32) + t2l_x;
			t3_s4   <= (t3h_x <<< 32) + t3l_x;
			dets_s4 <= dets_s3;
		end
	end

	// Stage 5: det(G) (never negative) and trace(adj(G) S)
	logic [DEN_W-1:0]    detg_s5;
	logic signed [100:0] tr_s5;
	logic signed [64:0]  dets_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			detg_s5 <= gg_s4 - q2_s4;
			tr_s5   <= 101'(t1_s4) + 101'(t2_s4) - 101'(t3_s4);
			dets_s5 <= dets_s4;
		end
	end

	// Stage 6: sign and magnitude, singular detect
	logic [DEN_W-1:0] detg_s6;
	logic             sing_s6, negs_s6, negt_s6;
	logic [63:0]      mags_s6;
	logic [99:0]      magt_s6;
	logic signed [64:0]  dets_abs;
	logic signed [100:0] tr_abs;

	always_comb begin
		dets_abs = dets_s5[64] ? -dets_s5 : dets_s5;
		tr_abs   = tr_s5[100] ? -tr_s5 : tr_s5;
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			detg_s6 <= detg_s5;
			sing_s6 <= (detg_s5 == '0);
			negs_s6 <= dets_s5[64];
			negt_s6 <= tr_s5[100];
			mags_s6 <= dets_abs[63:0];
			magt_s6 <= tr_abs[99:0];
		end
	end

	// Stage 7: doubled dividends with half-divisor rounding offset
	always_ff @(posedge clk) begin
		if (en_s7) begin
			out_data.num_g    <= (NUM_W'(mags_s6) << GAUSS_SHL) + NUM_W'(detg_s6);
			out_data.num_m    <= (NUM_W'(magt_s6) << MEAN_SHL) + NUM_W'(detg_s6);
			out_data.den2     <= {detg_s6, 1'b0};
			out_data.neg_g    <= negs_s6;
			out_data.neg_m    <= negt_s6;
			out_data.singular <= sing_s6;
		end
	end

endmodule
`default_nettype wire

FILE: src/tgmc_div.sv
`default_nettype none
module tgmc_div
	import tgmc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire tgmc_div_in_t in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output tgmc_out_t         out_data
);

	// Clamp one lane and apply its sign
	function automatic logic [OUT_W-1:0] sat_lane(
		input logic [DIV_BITS-1:0] q,
		input logic                big,
		input logic                neg
	);
		logic [OUT_W-1:0] r;
		if (neg) begin
			if (big || q > DIV_BITS'(SAT_NEG)) r = SAT_NEG;
			else r = OUT_W'(0) - q[OUT_W-1:0];
		end else begin
			if (big || q > DIV_BITS'(SAT_POS)) r = SAT_POS;
			else r = q[OUT_W-1:0];
		end
		return r;
	endfunction

	// Stage 0 checks the quotient range, stages 1..DIV_BITS each resolve one bit
	logic                v_s    [DIV_BITS+1];
	logic                en_s   [DIV_BITS+1];
	logic [REM_W-1:0]    rem_g_s[DIV_BITS+1];
	logic [REM_W-1:0]    rem_m_s[DIV_BITS+1];
	logic [DIV_BITS-1:0] q_g_s  [DIV_BITS+1];
	logic [DIV_BITS-1:0] q_m_s  [DIV_BITS+1];
	logic [DEN_W:0]      den_s  [DIV_BITS+1];
	logic                big_g_s[DIV_BITS+1];
	logic                big_m_s[DIV_BITS+1];
	logic                neg_g_s[DIV_BITS+1];
	logic                neg_m_s[DIV_BITS+1];
	logic                sing_s [DIV_BITS+1];
	logic                v_o_q, en_o;

	assign en_o = !v_o_q || out_ready;
	assign en_s[DIV_BITS] = !v_s[DIV_BITS] || en_o;
	assign in_ready = en_s[0];
	assign out_valid = v_o_q;

	// Range stage: quotient of 2^DIV_BITS or more always clamps
	logic [REM_W-1:0] top_w;
	assign top_w = REM_W'(in_data.den2) << DIV_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (en_s[0]) v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en_s[0]) begin
			rem_g_s[0] <= REM_W'(in_data.num_g);
			rem_m_s[0] <= REM_W'(in_data.num_m);
			big_g_s[0] <= REM_W'(in_data.num_g) >= top_w;
			big_m_s[0] <= REM_W'(in_data.num_m) >= top_w;
			q_g_s[0]   <= '0;
			q_m_s[0]   <= '0;
			den_s[0]   <= in_data.den2;
			neg_g_s[0] <= in_data.neg_g;
			neg_m_s[0] <= in_data.neg_m;
			sing_s[0]  <= in_data.singular;
		end
	end

	// Restoring steps, both lanes share the divisor
	for (genvar k = 1; k <= DIV_BITS; k++) begin : g_step
		localparam int B = DIV_BITS - k;
		logic [REM_W-1:0] ds;
		logic [REM_W:0]   dif_g, dif_m;

		if (k < DIV_BITS) begin : g_en
			assign en_s[k-1] = !v_s[k-1] || en_s[k];
		end else begin : g_en_last
			assign en_s[k-1] = !v_s[k-1] || en_s[k];
		end

		always_comb begin
			ds    = REM_W'(den_s[k-1]) << B;
			dif_g = {1'b0, rem_g_s[k-1]} - {1'b0, ds};
			dif_m = {1'b0, rem_m_s[k-1]} - {1'b0, ds};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k] <= 1'b0;
			else if (en_s[k]) v_s[k] <= v_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en_s[k]) begin
				rem_g_s[k]    <= dif_g[REM_W] ? rem_g_s[k-1] : dif_g[REM_W-1:0];
				rem_m_s[k]    <= dif_m[REM_W] ? rem_m_s[k-1] : dif_m[REM_W-1:0];
				q_g_s[k]      <= q_g_s[k-1]
					| (DIV_BITS'(!dif_g[REM_W]) << B);
				q_m_s[k]      <= q_m_s[k-1]
					| (DIV_BITS'(!dif_m[REM_W]) << B);
				den_s[k]      <= den_s[k-1];
				big_g_s[k]    <= big_g_s[k-1];
				big_m_s[k]    <= big_m_s[k-1];
				neg_g_s[k]    <= neg_g_s[k-1];
				neg_m_s[k]    <= neg_m_s[k-1];
				sing_s[k]     <= sing_s[k-1];
			end
		end
	end

	// Output register: clamp, apply sign, zero on singular metric
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_o_q <= 1'b0;
		else if (en_o) v_o_q <= v_s[DIV_BITS];
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			out_data.singular <= sing_s[DIV_BITS];
			if (sing_s[DIV_BITS]) begin
				out_data.gauss_curvature <= '0;
				out_data.mean_curvature  <= '0;
			end else begin
				out_data.gauss_curvature <= sat_lane(q_g_s[DIV_BITS], big_g_s[DIV_BITS],
					neg_g_s[DIV_BITS]);
				out_data.mean_curvature  <= sat_lane(q_m_s[DIV_BITS], big_m_s[DIV_BITS],
					neg_m_s[DIV_BITS]);
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/triangle_gauss_mean_curvature.sv
`default_nettype none
// Gauss and mean curvature per mesh triangle. Each input transaction carries the
// 3x2 deformation gradient F and the 2x2 second fundamental form S (signed Q16.16);
// each output transaction returns det(S)/det(F^T F) and 0.5*trace((F^T F)^-1 S) as
// signed Q24.24, rounded to nearest with ties away from zero and clamped to 48 bits.
// When det(F^T F) is zero the singular flag is set and both curvatures read zero.
// One triangle is taken every cycle unless the output stalls; 7 stages of 32-bit
// multiplies and wide sums build the exact determinant and trace, then a 51-stage
// pipelined restoring divider (one quotient bit per stage, both results side by side)
// rounds and clamps. Backpressure on the output stalls only the occupied stages.
module triangle_gauss_mean_curvature
	import tgmc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// f_00, f_10, f_20, f_01, f_11, f_21, s_00, s_01, s_10, s_11 (32 bits each)
	input  wire logic [319:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// gauss_curvature [47:0], mean_curvature [95:48]
	output logic [95:0]       m_axis_tdata,
	// singular
	output logic [0:0]        m_axis_tuser
);

	tgmc_in_t     in_w;
	tgmc_div_in_t div_in;
	tgmc_out_t    res;
	logic         div_valid, div_ready;

	assign in_w = s_axis_tdata;

	tgmc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (in_w),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_data  (div_in)
	);

	tgmc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_data   (div_in),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (res)
	);

	assign m_axis_tdata = {res.mean_curvature, res.gauss_curvature};
	assign m_axis_tuser = res.singular;

endmodule
`default_nettype wire
